[design/running_median_tracker_defines.svh]
// Assertion macros shared by the running median tracker RTL.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef RUNNING_MEDIAN_TRACKER_DEFINES_SVH
`define RUNNING_MEDIAN_TRACKER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rmt_pkg.sv]
// Shared types, operation codes and defaults for the running median tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmt_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEFAULT   = 1024;
  localparam int VALUE_BITS_DEFAULT = 17;

  // Fixed port field widths
  localparam int SAMPLE_BITS = 17;
  localparam int MEDIAN_BITS = 17;
  localparam int COUNT_BITS  = 11;

  // Chain operation applied to every cell at the same time
  typedef logic [2:0] op_t;

  localparam op_t OP_HOLD   = 3'd0;
  localparam op_t OP_INSERT = 3'd1;
  localparam op_t OP_PUSH   = 3'd2;
  localparam op_t OP_POP    = 3'd3;
  localparam op_t OP_CLEAR  = 3'd4;

endpackage

`default_nettype wire

[design/rmt_cell.sv]
// One cell of a sorted chain: holds one value and trades it with its neighbors.
// Depends on rmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmt_cell #(
  parameter int VALUE_BITS = rmt_pkg::VALUE_BITS_DEFAULT,
  parameter int CNT_BITS   = 10,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire rmt_pkg::op_t          op,
  input  wire logic [VALUE_BITS-1:0] key,
  input  wire logic [CNT_BITS-1:0]   fill,
  input  wire logic [VALUE_BITS-1:0] left_value,
  input  wire logic                  left_greater,
  input  wire logic [VALUE_BITS-1:0] right_value,
  output logic      [VALUE_BITS-1:0] value,
  output logic                       greater
);

  localparam logic [CNT_BITS-1:0] MY_POS = CNT_BITS'(IDX);

  logic                  at_end;
  logic [VALUE_BITS-1:0] value_next;

  // Occupied cell holding a value above the key
  assign greater = (MY_POS < fill) && (value > key);
  assign at_end  = (fill == MY_POS);

  // Pick the new content from the key or a neighbor
  always_comb begin
    value_next = value;
    unique case (op)
      rmt_pkg::OP_INSERT: begin
        if (greater || at_end) begin
          value_next = left_greater ? left_value : key;
        end
      end
      rmt_pkg::OP_PUSH: value_next = left_value;
      rmt_pkg::OP_POP:  value_next = right_value;
      default:          value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

[design/rmt_chain.sv]
// Row of rmt_cell kept in ascending order, with its fill count.
// Depends on rmt_pkg and rmt_cell.
`timescale 1ns / 1ps
`default_nettype none

module rmt_chain #(
  parameter int DEPTH      = 513,
  parameter int VALUE_BITS = rmt_pkg::VALUE_BITS_DEFAULT,
  parameter int CNT_BITS   = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rmt_pkg::op_t          op,
  input  wire logic [VALUE_BITS-1:0] key,
  output logic      [CNT_BITS-1:0]   fill,
  output logic      [VALUE_BITS-1:0] front
);

  logic [VALUE_BITS-1:0] values   [DEPTH];
  logic                  greaters [DEPTH];
  logic [CNT_BITS-1:0]   fill_next;

  // Build the row; the head takes the key from the left
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lv;
    logic                  lg;
    logic [VALUE_BITS-1:0] rv;

    if (i == 0) begin : g_head
      assign lv = key;
      assign lg = 1'b0;
    end else begin : g_body
      assign lv = values[i-1];
      assign lg = greaters[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = values[i];
    end else begin : g_inner
      assign rv = values[i+1];
    end

    rmt_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS),
      .IDX        (i)
    ) u_cell (
      .clk          (clk),
      .op           (op),
      .key          (key),
      .fill         (fill),
      .left_value   (lv),
      .left_greater (lg),
      .right_value  (rv),
      .value        (values[i]),
      .greater      (greaters[i])
    );
  end

  assign front = values[0];

  // Track how many cells hold data
  always_comb begin
    fill_next = fill;
    unique case (op) inside
      rmt_pkg::OP_INSERT,
      rmt_pkg::OP_PUSH:  fill_next = fill + CNT_BITS'(1);
      rmt_pkg::OP_POP:   fill_next = fill - CNT_BITS'(1);
      rmt_pkg::OP_CLEAR: fill_next = '0;
      default:           fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

[design/running_median_tracker.sv]
// Top level of the running median tracker: control sequence and two cell chains.
// Depends on rmt_pkg, rmt_chain and running_median_tracker_defines.svh.
//
// Usage:
//   Input: a transfer happens at a rising edge with start high and busy low;
//   sample and last are taken at that edge. busy stays high while the item
//   is being worked on.
//   Output: done is high for exactly one cycle with median, count and
//   overflow valid in that cycle. The receiver cannot stall the block.
//   Sequence: after the accepting edge the control runs three steps: sorted
//   insert into one chain, rebalance of the chains, and the registered
//   median add. done is high after the last step, and busy drops in that
//   same cycle, so a new item is taken only once the last result is out.
//   The samples are split over two sorted chains of cells: the lower half
//   (stored inverted, so its largest value sits at the head) and the upper
//   half (smallest value at the head). The median is read from the heads.
//   Once CAPACITY samples are held, further samples are dropped and flagged
//   by overflow. An item with last set clears both chains after its result.
//   Reset: rst empties both chains and returns the control to idle; no
//   clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "running_median_tracker_defines.svh"

module running_median_tracker #(
  parameter int CAPACITY   = rmt_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_BITS = rmt_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [rmt_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic                            last,
  output logic                                 busy,
  output logic                                 done,
  output logic      [rmt_pkg::MEDIAN_BITS-1:0] median,
  output logic      [rmt_pkg::COUNT_BITS-1:0]  count,
  output logic                                 overflow
);

  localparam int DEPTH      = CAPACITY / 2 + 1;
  localparam int CB         = $clog2(DEPTH + 1);
  localparam int TOTAL_BITS = $clog2(CAPACITY + 1);
  localparam logic [TOTAL_BITS-1:0] FULL_COUNT = TOTAL_BITS'(CAPACITY);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_INSERT  = 2'd1;
  localparam logic [1:0] ST_BALANCE = 2'd2;
  localparam logic [1:0] ST_RESULT  = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [VALUE_BITS-1:0] sample_reg;
  logic                  last_reg;
  logic                  ovf_reg;

  rmt_pkg::op_t          low_op;
  rmt_pkg::op_t          up_op;
  logic [VALUE_BITS-1:0] low_key;
  logic [VALUE_BITS-1:0] up_key;
  logic [CB-1:0]         low_cnt;
  logic [CB-1:0]         up_cnt;
  logic [VALUE_BITS-1:0] low_head_raw;
  logic [VALUE_BITS-1:0] low_head;
  logic [VALUE_BITS-1:0] up_head;
  logic [TOTAL_BITS-1:0] total;
  logic                  full;
  logic [VALUE_BITS:0]   mid_sum;
  logic [VALUE_BITS-1:0] mid_value;

  assign busy     = (state != ST_IDLE);
  assign low_head = ~low_head_raw;
  assign total    = TOTAL_BITS'(low_cnt) + TOTAL_BITS'(up_cnt);
  assign full     = (total == FULL_COUNT);

  // Median from the two chain heads
  assign mid_sum   = {1'b0, low_head} + {1'b0, up_head};
  assign mid_value = total[0] ? low_head : mid_sum[VALUE_BITS:1];

  // Sequence: insert, rebalance, result
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = ST_INSERT;
      ST_INSERT:  state_next = ST_BALANCE;
      ST_BALANCE: state_next = ST_RESULT;
      ST_RESULT:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Drive the chain operations for each step
  always_comb begin
    low_op  = rmt_pkg::OP_HOLD;
    up_op   = rmt_pkg::OP_HOLD;
    low_key = ~sample_reg;
    up_key  = sample_reg;
    unique case (state)
      ST_INSERT: begin
        if (!full) begin
          if ((low_cnt == '0) || (sample_reg <= low_head)) begin
            low_op = rmt_pkg::OP_INSERT;
          end else begin
            up_op = rmt_pkg::OP_INSERT;
          end
        end
      end
      ST_BALANCE: begin
        if ({1'b0, low_cnt} > ({1'b0, up_cnt} + (CB + 1)'(1))) begin
          low_op = rmt_pkg::OP_POP;
          up_op  = rmt_pkg::OP_PUSH;
          up_key = low_head;
        end else if (up_cnt > low_cnt) begin
          up_op   = rmt_pkg::OP_POP;
          low_op  = rmt_pkg::OP_PUSH;
          low_key = ~up_head;
        end
      end
      ST_RESULT: begin
        if (last_reg) begin
          low_op = rmt_pkg::OP_CLEAR;
          up_op  = rmt_pkg::OP_CLEAR;
        end
      end
      default: begin
        low_op = rmt_pkg::OP_HOLD;
        up_op  = rmt_pkg::OP_HOLD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_RESULT);
    end
  end

  // Capture the item and the result payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sample_reg <= VALUE_BITS'(sample);
      last_reg   <= last;
    end
    if (state == ST_INSERT) begin
      ovf_reg <= full;
    end
    if (state == ST_RESULT) begin
      median   <= rmt_pkg::MEDIAN_BITS'(mid_value);
      count    <= rmt_pkg::COUNT_BITS'(total);
      overflow <= ovf_reg;
    end
  end

  // Lower half, stored inverted so its maximum is at the head
  rmt_chain #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .CNT_BITS   (CB)
  ) u_low (
    .clk   (clk),
    .rst   (rst),
    .op    (low_op),
    .key   (low_key),
    .fill  (low_cnt),
    .front (low_head_raw)
  );

  // Upper half, minimum at the head
  rmt_chain #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .CNT_BITS   (CB)
  ) u_up (
    .clk   (clk),
    .rst   (rst),
    .op    (up_op),
    .key   (up_key),
    .fill  (up_cnt),
    .front (up_head)
  );

  `RMT_ASSERT_SAME(a_halves_balanced, state == ST_RESULT,
    (low_cnt == up_cnt) || ({1'b0, low_cnt} == ({1'b0, up_cnt} + (CB + 1)'(1))),
    "chain fill counts out of balance at result")

  `RMT_ASSERT_SAME(a_halves_ordered, (state == ST_RESULT) && (up_cnt != '0),
    low_head <= up_head, "lower half head above upper half head")

  `RMT_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")

  `RMT_ASSERT_NEXT(a_result_latency, start && !busy, ##3 done,
    "no result four cycles after transfer")

  `RMT_ASSERT_SAME(a_nonempty_result, state == ST_RESULT, total != '0,
    "result produced with empty store")

endmodule

`default_nettype wire
